>>> design/lnbpwr_pkg.sv
// Shared types and constants for the LNB rail power controller.
// Holds the request and result word layouts, status and rail state codes.
// No dependencies; imported by the controller, the result checker and the testbench.
package lnbpwr_pkg;

	// Requested voltage that selects the high supply level.
	localparam logic [3:0] HIGH_VOLTS = 4'd15;

	// Number of slots that carry marks: receivers 0, 1, 4 and 5.
	localparam int NUM_SLOTS = 4;

	typedef enum logic [2:0] {
		ACT_BEGIN      = 3'd0,
		ACT_COMMIT     = 3'd1,
		ACT_ROLLBACK   = 3'd2,
		ACT_RELEASE    = 3'd3,
		ACT_RECONCILE  = 3'd4,
		ACT_SHUTDOWN   = 3'd5,
		ACT_DISCONNECT = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID      = 3'd1,
		ST_UNSUPPORTED  = 3'd2,
		ST_DISCONNECTED = 3'd3,
		ST_BUSY         = 3'd4,
		ST_FAILED       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		RAIL_OFF     = 2'd0,
		RAIL_ON      = 2'd1,
		RAIL_UNKNOWN = 2'd2,
		RAIL_DISC    = 2'd3
	} rail_state_t;

	// Drive outcome codes; any other code is a plain failure.
	localparam logic [1:0] OUTC_OK   = 2'd0;
	localparam logic [1:0] OUTC_DISC = 2'd1;

	// Per-slot reference marks.
	typedef struct packed {
		logic comm_hi;
		logic comm;
		logic pend_hi;
		logic pend;
	} marks_t;

	// Result of one drive attempt on a rail.
	typedef struct packed {
		logic        issued;
		rail_state_t st;
		logic        debt;
		status_t     status;
	} apply_res_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] receiver;
		logic [3:0] voltage;
		logic [1:0] rail_select;
		logic [1:0] first_drive_outcome;
		logic [1:0] second_drive_outcome;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] drives_issued;
		logic       drive_a_rail;
		logic       drive_a_on;
		logic       drive_b_rail;
		logic       drive_b_on;
		logic [1:0] users_rail_zero;
		logic [1:0] users_rail_one;
		logic [1:0] state_rail_zero;
		logic [1:0] state_rail_one;
		logic       debt_rail_zero;
		logic       debt_rail_one;
	} out_word_t;

endpackage

>>> design/lnb_power_refcount_controller.sv
// Reference-counted power controller for two LNB supply rails.
// Request register, one pass of decision logic, registered result word.
// Depends on lnbpwr_pkg for word layouts and codes.
//
// Usage: a request word (action, receiver, voltage, rail select and the
// outcomes of up to two drive attempts) enters on in_valid/in_stall. Each
// request yields exactly one result word on out_valid/out_stall carrying
// the status, the drive commands issued, the per-rail user counts, the rail
// states and the cleanup debts after the action.
// The accepted word sits in the request register and the decision logic
// loads the result register from it when the pipeline advances.
// Throughput is one word per cycle while out_stall does not hold the
// result register; the rail and slot state is updated as the result is
// registered, so the next request sees it.
// When the receiver stalls, the result register holds and one more request
// is still taken into the request register; in_stall rises only when both
// registers are full and the output is stalled.
// Reset clears all slot marks, puts both rails off with no debt, forbids
// 15 V requests and empties both registers. cfg_wr_en/cfg_wr_data write
// the high-voltage enable and should only be used while the block is idle.
module lnb_power_refcount_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lnbpwr_pkg::in_word_t  in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lnbpwr_pkg::out_word_t out_word
);
	import lnbpwr_pkg::*;

	logic        allow_hv_q;
	logic        req_valid_s1;
	in_word_t    req_s1;
	logic        res_valid_q;
	out_word_t   res_q;
	marks_t      marks_q [NUM_SLOTS];
	rail_state_t rail_st_q [2];
	logic [1:0]  rail_debt_q;

	logic        advance;
	marks_t      marks_n [NUM_SLOTS];
	rail_state_t rail_st_n [2];
	logic [1:0]  rail_debt_n;
	status_t     status_n;
	logic [1:0]  n_drv;
	logic [1:0]  drv_rail_n;
	logic [1:0]  drv_on_n;
	out_word_t   res_n;

	// Whether one slot wants its rail powered.
	function automatic logic slot_wants(input marks_t m);
		return m.pend ? m.pend_hi : (m.comm & m.comm_hi);
	endfunction

	// One drive decision for a rail, given its wanted level and the outcome code.
	function automatic apply_res_t apply_rail(input logic want_on, input rail_state_t st,
			input logic debt, input logic [1:0] outc);
		apply_res_t r;
		r.issued = 1'b0;
		r.st     = st;
		r.debt   = debt;
		r.status = ST_OK;
		if (st == RAIL_DISC) begin
			r.status = ST_DISCONNECTED;
		end else if (!((want_on && st == RAIL_ON) ||
				(!want_on && st == RAIL_OFF && !debt))) begin
			r.issued = 1'b1;
			if (outc == OUTC_OK) begin
				r.st   = want_on ? RAIL_ON : RAIL_OFF;
				r.debt = 1'b0;
			end else if (outc == OUTC_DISC) begin
				r.st     = RAIL_DISC;
				r.debt   = 1'b0;
				r.status = ST_DISCONNECTED;
			end else begin
				r.st     = RAIL_UNKNOWN;
				r.debt   = 1'b1;
				r.status = ST_FAILED;
			end
		end
		return r;
	endfunction

	// Pipeline moves when the result register is empty or being taken.
	assign advance   = !res_valid_q || !out_stall;
	assign in_stall  = req_valid_s1 && !advance;
	assign out_valid = res_valid_q;
	assign out_word  = res_q;

	// Decision logic for the request held in the request register.
	always_comb begin
		logic [1:0] slot;
		logic       rail_a;
		logic       rail_b;
		logic       slot_ok;
		logic       do_a;
		logic       retry;
		logic       both;
		logic       want;
		apply_res_t ar_a;
		apply_res_t ar_b;
		logic [1:0] outc_b;

		marks_n     = marks_q;
		rail_st_n   = rail_st_q;
		rail_debt_n = rail_debt_q;
		status_n    = ST_OK;
		n_drv       = 2'd0;
		drv_rail_n  = 2'b00;
		drv_on_n    = 2'b00;
		slot        = {req_s1.receiver[2], req_s1.receiver[0]};
		slot_ok     = !req_s1.receiver[1];
		rail_a      = req_s1.receiver[2];
		rail_b      = rail_a;
		do_a        = 1'b0;
		retry       = 1'b0;
		both        = 1'b0;
		ar_a        = '0;
		ar_b        = '0;
		want        = 1'b0;
		outc_b      = req_s1.first_drive_outcome;

		// Argument checks and mark updates that precede any drive.
		case (action_t'(req_s1.action))
			ACT_BEGIN: begin
				if (!slot_ok || (req_s1.voltage != 4'd0 && req_s1.voltage != HIGH_VOLTS)) begin
					status_n = ST_INVALID;
				end else if (req_s1.voltage == HIGH_VOLTS && !allow_hv_q) begin
					status_n = ST_UNSUPPORTED;
				end else if (rail_st_q[0] == RAIL_DISC || rail_st_q[1] == RAIL_DISC) begin
					status_n = ST_DISCONNECTED;
				end else if (marks_q[slot].pend) begin
					status_n = ST_BUSY;
				end else begin
					marks_n[slot].pend    = 1'b1;
					marks_n[slot].pend_hi = (req_s1.voltage == HIGH_VOLTS);
					do_a  = 1'b1;
					retry = 1'b1;
				end
			end
			ACT_COMMIT: begin
				if (!slot_ok || !marks_q[slot].pend) begin
					status_n = ST_INVALID;
				end else begin
					marks_n[slot].comm_hi = marks_q[slot].pend_hi;
					marks_n[slot].comm    = 1'b1;
					marks_n[slot].pend    = 1'b0;
				end
			end
			ACT_ROLLBACK: begin
				if (!slot_ok || !marks_q[slot].pend) begin
					status_n = ST_INVALID;
				end else begin
					marks_n[slot].pend = 1'b0;
					do_a = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if (!slot_ok) begin
					status_n = ST_INVALID;
				end else begin
					marks_n[slot] = '0;
					do_a = 1'b1;
				end
			end
			ACT_RECONCILE: begin
				rail_a = 1'b0;
				rail_b = 1'b1;
				do_a   = 1'b1;
				both   = 1'b1;
			end
			ACT_SHUTDOWN: begin
				marks_n = '{default: '0};
				rail_a = 1'b0;
				rail_b = 1'b1;
				do_a   = 1'b1;
				both   = 1'b1;
			end
			ACT_DISCONNECT: begin
				if (req_s1.rail_select[1]) begin
					status_n = ST_INVALID;
				end else begin
					rail_st_n[req_s1.rail_select[0]]   = RAIL_DISC;
					rail_debt_n[req_s1.rail_select[0]] = 1'b0;
					marks_n[{req_s1.rail_select[0], 1'b0}] = '0;
					marks_n[{req_s1.rail_select[0], 1'b1}] = '0;
				end
			end
			default: begin
				status_n = ST_INVALID;
			end
		endcase

		// First drive attempt.
		if (do_a) begin
			want = slot_wants(marks_n[{rail_a, 1'b0}]) | slot_wants(marks_n[{rail_a, 1'b1}]);
			ar_a = apply_rail(want, rail_st_n[rail_a], rail_debt_n[rail_a],
				req_s1.first_drive_outcome);
			rail_st_n[rail_a]   = ar_a.st;
			rail_debt_n[rail_a] = ar_a.debt;
			status_n            = ar_a.status;
			if (ar_a.issued) begin
				drv_rail_n[0] = rail_a;
				drv_on_n[0]   = want;
				n_drv         = 2'd1;
				outc_b        = req_s1.second_drive_outcome;
			end
		end

		// A failed begin drops its pending mark and drives the rail back.
		if (retry && ar_a.status != ST_OK) begin
			marks_n[slot].pend = 1'b0;
		end

		// Second drive attempt: retry of a begin, or rail one of a sweep.
		if (both || (retry && ar_a.status != ST_OK)) begin
			want = slot_wants(marks_n[{rail_b, 1'b0}]) | slot_wants(marks_n[{rail_b, 1'b1}]);
			ar_b = apply_rail(want, rail_st_n[rail_b], rail_debt_n[rail_b], outc_b);
			rail_st_n[rail_b]   = ar_b.st;
			rail_debt_n[rail_b] = ar_b.debt;
			if (ar_b.issued) begin
				drv_rail_n[n_drv[0]] = rail_b;
				drv_on_n[n_drv[0]]   = want;
				n_drv                = n_drv + 2'd1;
			end
			if (both) begin
				status_n = (ar_a.status != ST_OK) ? ar_a.status : ar_b.status;
			end else if (ar_b.status == ST_DISCONNECTED) begin
				status_n = ST_DISCONNECTED;
			end
		end

		// Result word, counted after the action.
		res_n.status          = status_n;
		res_n.drives_issued   = n_drv;
		res_n.drive_a_rail    = drv_rail_n[0];
		res_n.drive_a_on      = drv_on_n[0];
		res_n.drive_b_rail    = drv_rail_n[1];
		res_n.drive_b_on      = drv_on_n[1];
		res_n.users_rail_zero = {1'b0, slot_wants(marks_n[0])} +
			{1'b0, slot_wants(marks_n[1])};
		res_n.users_rail_one  = {1'b0, slot_wants(marks_n[2])} +
			{1'b0, slot_wants(marks_n[3])};
		res_n.state_rail_zero = rail_st_n[0];
		res_n.state_rail_one  = rail_st_n[1];
		res_n.debt_rail_zero  = rail_debt_n[0];
		res_n.debt_rail_one   = rail_debt_n[1];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_hv_q <= 1'b0;
		end else if (cfg_wr_en) begin
			allow_hv_q <= cfg_wr_data;
		end
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			req_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= in_word;
		end
	end

	// Result register and state update, both taken when the request advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			rail_debt_q <= 2'b00;
			marks_q     <= '{default: '0};
			rail_st_q   <= '{default: RAIL_OFF};
		end else if (advance) begin
			res_valid_q <= req_valid_s1;
			if (req_valid_s1) begin
				marks_q     <= marks_n;
				rail_st_q   <= rail_st_n;
				rail_debt_q <= rail_debt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1) begin
			res_q <= res_n;
		end
	end

`ifndef NO_ASSERTIONS
	// The input side only backs up when both registers are full and stalled.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (req_valid_s1 && res_valid_q && out_stall))
		else $error("input stalled while the pipeline has room");

	// Drive fields stay zero when no drive was issued.
	a_unused_drives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.drives_issued == 2'd0) |->
		(!res_q.drive_a_rail && !res_q.drive_a_on && !res_q.drive_b_rail && !res_q.drive_b_on))
		else $error("drive fields set with no drive issued");

	// A cleanup debt exists only on a rail left in the unknown state.
	a_debt_implies_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(!rail_debt_q[0] || rail_st_q[0] == RAIL_UNKNOWN) &&
		(!rail_debt_q[1] || rail_st_q[1] == RAIL_UNKNOWN))
		else $error("rail debt without unknown state");

	// Rail zero, once disconnected, stays disconnected until reset.
	a_disc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(rail_st_q[0] == RAIL_DISC) |-> rail_st_q[0] == RAIL_DISC)
		else $error("rail zero left the disconnected state");

	// At most two drives come from one request.
	a_drive_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.drives_issued != 2'd3)
		else $error("more than two drives reported");
`endif

endmodule

>>> dv/lnbpwr_result_checker.sv
// Result checker for the LNB rail power controller testbench.
// Watches the request and result channels, predicts each result word and compares it.
// Depends on lnbpwr_pkg for the word layouts, status and rail state codes.
module lnbpwr_result_checker
	import lnbpwr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_word_t out_word,
	output int        error_count,
	output int        outstanding
);

	// Predicted controller state and configuration.
	marks_t      slot_marks [8];
	rail_state_t rail_st [2];
	logic        rail_debt [2];
	logic        allow_hv;

	// Drive commands issued by the action being predicted.
	int          drives;
	logic        drv_rail [2];
	logic        drv_on [2];
	logic [1:0]  drv_outc [2];

	// Result words predicted but not yet seen, oldest first.
	out_word_t   expected_results [$];

	initial error_count = 0;

	function automatic logic slot_ok(input logic [2:0] rcv);
		return rcv == 3'd0 || rcv == 3'd1 || rcv == 3'd4 || rcv == 3'd5;
	endfunction

	// Count the slots of a rail that want power.
	function automatic logic [1:0] count_wanting(input logic rail);
		logic [1:0] n;
		marks_t     m;
		n = '0;
		for (int k = 0; k < 2; k++) begin
			m = slot_marks[{rail, 1'b0, k[0]}];
			if (m.pend ? m.pend_hi : (m.comm && m.comm_hi))
				n++;
		end
		return n;
	endfunction

	// Bring one rail to its wanted level, consuming the next drive outcome.
	function automatic status_t drive_rail(input logic rail);
		logic       want_on;
		logic [1:0] outc;
		want_on = count_wanting(rail) != 2'd0;
		if (rail_st[rail] == RAIL_DISC)
			return ST_DISCONNECTED;
		if ((want_on && rail_st[rail] == RAIL_ON) ||
		    (!want_on && rail_st[rail] == RAIL_OFF && !rail_debt[rail]))
			return ST_OK;
		if (drives < 2) begin
			drv_rail[drives[0]] = rail;
			drv_on[drives[0]] = want_on;
			outc = drv_outc[drives[0]];
			drives++;
		end else begin
			outc = drv_outc[1];
		end
		if (outc == OUTC_OK) begin
			rail_st[rail] = want_on ? RAIL_ON : RAIL_OFF;
			rail_debt[rail] = 1'b0;
			return ST_OK;
		end
		if (outc == OUTC_DISC) begin
			rail_st[rail] = RAIL_DISC;
			rail_debt[rail] = 1'b0;
			return ST_DISCONNECTED;
		end
		rail_st[rail] = RAIL_UNKNOWN;
		rail_debt[rail] = 1'b1;
		return ST_FAILED;
	endfunction

	// Apply rail zero then rail one; the first error wins.
	function automatic status_t drive_both();
		status_t first_err;
		status_t s;
		first_err = ST_OK;
		for (int rail = 0; rail < 2; rail++) begin
			s = drive_rail(rail == 1);
			if (s != ST_OK && first_err == ST_OK)
				first_err = s;
		end
		return first_err;
	endfunction

	// Work out the result word of one request word and update the state.
	function automatic out_word_t predict_power_action(input in_word_t w);
		out_word_t res;
		status_t   st;
		status_t   first_try;
		marks_t    m;
		logic      rail;
		st = ST_OK;
		drives = 0;
		drv_rail = '{default: 1'b0};
		drv_on = '{default: 1'b0};
		drv_outc[0] = w.first_drive_outcome;
		drv_outc[1] = w.second_drive_outcome;
		rail = w.receiver[2];
		m = slot_marks[w.receiver];
		case (w.action)
			ACT_BEGIN: begin
				if (!slot_ok(w.receiver) || (w.voltage != 4'd0 && w.voltage != HIGH_VOLTS)) begin
					st = ST_INVALID;
				end else if (w.voltage == HIGH_VOLTS && !allow_hv) begin
					st = ST_UNSUPPORTED;
				end else if (rail_st[0] == RAIL_DISC || rail_st[1] == RAIL_DISC) begin
					st = ST_DISCONNECTED;
				end else if (m.pend) begin
					st = ST_BUSY;
				end else begin
					m.pend = 1'b1;
					m.pend_hi = w.voltage == HIGH_VOLTS;
					slot_marks[w.receiver] = m;
					first_try = drive_rail(rail);
					st = first_try;
					// A failed power-up backs the pending mark out and restores the rail.
					if (first_try != ST_OK) begin
						m.pend = 1'b0;
						slot_marks[w.receiver] = m;
						if (drive_rail(rail) == ST_DISCONNECTED)
							st = ST_DISCONNECTED;
					end
				end
			end
			ACT_COMMIT: begin
				if (!slot_ok(w.receiver) || !m.pend) begin
					st = ST_INVALID;
				end else begin
					m.comm_hi = m.pend_hi;
					m.comm = 1'b1;
					m.pend = 1'b0;
					slot_marks[w.receiver] = m;
				end
			end
			ACT_ROLLBACK: begin
				if (!slot_ok(w.receiver) || !m.pend) begin
					st = ST_INVALID;
				end else begin
					m.pend = 1'b0;
					slot_marks[w.receiver] = m;
					st = drive_rail(rail);
				end
			end
			ACT_RELEASE: begin
				if (!slot_ok(w.receiver)) begin
					st = ST_INVALID;
				end else begin
					slot_marks[w.receiver] = '0;
					st = drive_rail(rail);
				end
			end
			ACT_RECONCILE: begin
				st = drive_both();
			end
			ACT_SHUTDOWN: begin
				slot_marks = '{default: '0};
				st = drive_both();
			end
			ACT_DISCONNECT: begin
				if (w.rail_select > 2'd1) begin
					st = ST_INVALID;
				end else begin
					rail_st[w.rail_select[0]] = RAIL_DISC;
					rail_debt[w.rail_select[0]] = 1'b0;
					slot_marks[{w.rail_select[0], 2'b00}] = '0;
					slot_marks[{w.rail_select[0], 2'b01}] = '0;
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
		res.status = st;
		res.drives_issued = drives[1:0];
		res.drive_a_rail = drv_rail[0];
		res.drive_a_on = drv_on[0];
		res.drive_b_rail = drv_rail[1];
		res.drive_b_on = drv_on[1];
		res.users_rail_zero = count_wanting(1'b0);
		res.users_rail_one = count_wanting(1'b1);
		res.state_rail_zero = rail_st[0];
		res.state_rail_one = rail_st[1];
		res.debt_rail_zero = rail_debt[0];
		res.debt_rail_one = rail_debt[1];
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, actual %0d", name, exp, act);
			error_count++;
		end
	endtask

	// Predict on every accepted request word, compare on every accepted result word.
	always @(posedge clk or negedge arst_n) begin
		out_word_t exp;
		if (!arst_n) begin
			slot_marks = '{default: '0};
			rail_st = '{default: RAIL_OFF};
			rail_debt = '{default: 1'b0};
			allow_hv = 1'b0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				allow_hv = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_results.push_back(predict_power_action(in_word));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result word with no prediction waiting");
					error_count++;
				end else begin
					exp = expected_results.pop_front();
					check_field("status", 8'(exp.status), 8'(out_word.status));
					check_field("drives_issued", 8'(exp.drives_issued),
						8'(out_word.drives_issued));
					check_field("drive_a_rail", 8'(exp.drive_a_rail),
						8'(out_word.drive_a_rail));
					check_field("drive_a_on", 8'(exp.drive_a_on), 8'(out_word.drive_a_on));
					check_field("drive_b_rail", 8'(exp.drive_b_rail),
						8'(out_word.drive_b_rail));
					check_field("drive_b_on", 8'(exp.drive_b_on), 8'(out_word.drive_b_on));
					check_field("users_rail_zero", 8'(exp.users_rail_zero),
						8'(out_word.users_rail_zero));
					check_field("users_rail_one", 8'(exp.users_rail_one),
						8'(out_word.users_rail_one));
					check_field("state_rail_zero", 8'(exp.state_rail_zero),
						8'(out_word.state_rail_zero));
					check_field("state_rail_one", 8'(exp.state_rail_one),
						8'(out_word.state_rail_one));
					check_field("debt_rail_zero", 8'(exp.debt_rail_zero),
						8'(out_word.debt_rail_zero));
					check_field("debt_rail_one", 8'(exp.debt_rail_one),
						8'(out_word.debt_rail_one));
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> dv/lnb_power_refcount_controller_test.sv
// Top of the LNB rail power controller testbench: clock, reset, request and stall stimulus.
// Instantiates lnb_power_refcount_controller and lnbpwr_result_checker; uses lnbpwr_pkg.
module lnb_power_refcount_controller_test;
	import lnbpwr_pkg::*;

	localparam logic [2:0] ACT_UNDEFINED = 3'd7;
	localparam logic [1:0] OUTC_FAIL     = 2'd2;
	localparam logic [1:0] OUTC_FAIL_ALT = 2'd3;
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;
	int        error_count;
	int        outstanding;
	int        idle_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lnb_power_refcount_controller u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

	lnbpwr_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// Sender gaps: mostly none or short, a few long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drive outcomes: mostly success; disconnects only where the run can afford them.
	function automatic logic [1:0] pick_outcome(input bit with_disc);
		int p;
		p = $urandom_range(0, 99);
		if (with_disc && p < 10)
			return OUTC_DISC;
		if (p < 80)
			return OUTC_OK;
		return (p < 90) ? OUTC_FAIL : OUTC_FAIL_ALT;
	endfunction

	// Random request word, weighted toward valid slots and legal voltages.
	function automatic in_word_t rand_word(input bit with_disc);
		in_word_t w;
		int       p;
		p = $urandom_range(0, 99);
		if (p < 30)
			w.action = ACT_BEGIN;
		else if (p < 45)
			w.action = ACT_COMMIT;
		else if (p < 57)
			w.action = ACT_ROLLBACK;
		else if (p < 72)
			w.action = ACT_RELEASE;
		else if (p < 84)
			w.action = ACT_RECONCILE;
		else if (p < 90)
			w.action = ACT_SHUTDOWN;
		else if (p < 96)
			w.action = ACT_DISCONNECT;
		else
			w.action = ACT_UNDEFINED;
		if ($urandom_range(0, 9) == 0)
			w.receiver = 3'($urandom_range(0, 7));
		else
			w.receiver = {$urandom_range(0, 1) == 1, 1'b0, $urandom_range(0, 1) == 1};
		p = $urandom_range(0, 99);
		if (p < 45)
			w.voltage = 4'd0;
		else if (p < 90)
			w.voltage = HIGH_VOLTS;
		else
			w.voltage = 4'($urandom_range(0, 15));
		// A disconnect is permanent, so outside the last phase only bad selects are sent.
		if (w.action == ACT_DISCONNECT && !with_disc)
			w.rail_select = 2'($urandom_range(2, 3));
		else
			w.rail_select = 2'($urandom_range(0, 3));
		w.first_drive_outcome = pick_outcome(with_disc);
		w.second_drive_outcome = pick_outcome(with_disc);
		return w;
	endfunction

	// Offer one request word after a gap and hold it until it is accepted.
	task automatic send_word(input in_word_t w, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_req(input logic [2:0] act, input logic [2:0] rcv, input logic [3:0] volts,
	                        input logic [1:0] sel, input logic [1:0] o1, input logic [1:0] o2);
		in_word_t w;
		w.action = act;
		w.receiver = rcv;
		w.voltage = volts;
		w.rail_select = sel;
		w.first_drive_outcome = o1;
		w.second_drive_outcome = o2;
		send_word(w, pick_gap());
	endtask

	// Random words in chunks, some chunks sent back to back.
	task automatic run_random(input int n, input bit with_disc);
		bit burst;
		burst = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0)
				burst = $urandom_range(0, 2) == 0;
			send_word(rand_word(with_disc), burst ? 0 : pick_gap());
		end
	endtask

	// Stop offering and wait until every predicted result word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic set_allow_hv(input logic enable);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= enable;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver stall: random runs, plus one long hold-off once traffic is flowing.
	initial begin
		int results_seen;
		int run_len;
		int p;
		bit held;
		bit stall_now;
		results_seen = 0;
		held = 1'b0;
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				stall_now = 1'b1;
				run_len = HOLD_CYCLES;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 65) begin
					stall_now = 1'b0;
					run_len = $urandom_range(1, 30);
				end else if (p < 95) begin
					stall_now = 1'b1;
					run_len = $urandom_range(1, 3);
				end else begin
					stall_now = 1'b1;
					run_len = $urandom_range(20, 80);
				end
			end
			out_stall <= stall_now;
			repeat (run_len) begin
				@(posedge clk);
				if (out_valid && !out_stall)
					results_seen++;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("lnb_power_refcount_controller_test: errors");
			$finish;
		end
	end

	// Main sequence: directed checks, random phases under each setting, disconnect phase last.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// High voltage refused; argument checks and the plain pend/commit flow.
		set_allow_hv(1'b0);
		send_req(ACT_BEGIN, 3'd0, HIGH_VOLTS, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd2, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd0, 4'd7, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_COMMIT, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_COMMIT, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_ROLLBACK, 3'd3, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_UNDEFINED, 3'd7, 4'd15, 2'd3, OUTC_FAIL_ALT, OUTC_FAIL_ALT);
		drain();

		// High voltage allowed: power-up, failed power-up with restore, cleanup debt.
		set_allow_hv(1'b1);
		send_req(ACT_BEGIN, 3'd1, HIGH_VOLTS, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd4, HIGH_VOLTS, 2'd0, OUTC_FAIL, OUTC_OK);
		send_req(ACT_BEGIN, 3'd5, HIGH_VOLTS, 2'd0, OUTC_FAIL_ALT, OUTC_FAIL);
		send_req(ACT_RECONCILE, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd4, HIGH_VOLTS, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_ROLLBACK, 3'd4, 4'd0, 2'd0, OUTC_FAIL, OUTC_OK);
		send_req(ACT_RELEASE, 3'd7, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_COMMIT, 3'd1, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd1, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_ROLLBACK, 3'd1, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_SHUTDOWN, 3'd0, 4'd0, 2'd0, OUTC_FAIL, OUTC_OK);
		send_req(ACT_RECONCILE, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_RECONCILE, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);

		// Random phases under both settings, rails kept connected.
		run_random(500, 1'b0);
		drain();
		set_allow_hv(1'b0);
		run_random(500, 1'b0);
		drain();
		set_allow_hv(1'b1);
		run_random(450, 1'b0);

		// Disconnects stick until reset, so they come last.
		send_req(ACT_DISCONNECT, 3'd0, 4'd0, 2'd3, OUTC_OK, OUTC_OK);
		send_req(ACT_BEGIN, 3'd5, HIGH_VOLTS, 2'd0, OUTC_DISC, OUTC_OK);
		send_req(ACT_BEGIN, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_RECONCILE, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_DISCONNECT, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_RELEASE, 3'd1, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		send_req(ACT_COMMIT, 3'd0, 4'd0, 2'd0, OUTC_OK, OUTC_OK);
		run_random(80, 1'b1);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("lnb_power_refcount_controller_test: clean");
		else
			$display("lnb_power_refcount_controller_test: errors");
		$finish;
	end

endmodule

>>> filelist.f
design/lnbpwr_pkg.sv
design/lnb_power_refcount_controller.sv
dv/lnbpwr_result_checker.sv
dv/lnb_power_refcount_controller_test.sv
